FILE: src/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned CODE_W  = 2;

	localparam int unsigned BUFFER_BYTES_DEF = 2048;
	localparam logic [INDEX_W-1:0] MAX_PAYLOAD_RST = 11'd2047;

	// framing characters
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_START  = 8'h24; // '$'
	localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23; // '#'
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A; // ':'
	localparam logic [INDEX_W-1:0] COLON_POS = 11'd2;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_DATA = 2'd1,
		PH_CK1  = 2'd2,
		PH_CK2  = 2'd3
	} phase_t;

	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		ST_OK         = 2'd0,
		ST_DEPRECATED = 2'd1,
		ST_CKSUM      = 2'd2,
		ST_READ       = 2'd3
	} status_t;

	typedef enum logic [CODE_W-1:0] {
		ACK_NONE  = 2'd0,
		ACK_PLUS  = 2'd1,
		ACK_MINUS = 2'd2
	} ack_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [INDEX_W-1:0]  byte_index;
		status_t             status;
		ack_t                ack;
	} res_t;

	// hex digit value, anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			v = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			v = c[3:0] + 4'd9;
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: src/cpd_parser.sv
`default_nettype none

module cpd_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [cpd_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic [cpd_pkg::INDEX_W-1:0] limit,
	output logic                             emit,
	output cpd_pkg::res_t                    res
);
	import cpd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [BYTE_W-1:0]    sum_q, sum_d;
	logic [INDEX_W-1:0]   count_q, count_d;
	logic                 colon_q, colon_d;
	logic [3:0]           nib_q, nib_d;
	logic [INDEX_W:0]     count_inc;
	logic [BYTE_W-1:0]    given;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			count_q <= '0;
			colon_q <= 1'b0;
			nib_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			colon_q <= colon_d;
			nib_q   <= nib_d;
		end
	end

	assign count_inc = {1'b0, count_q} + {{INDEX_W{1'b0}}, 1'b1};
	assign given     = {nib_q, hex_value(rx_byte)};

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		count_d = count_q;
		colon_d = colon_q;
		nib_d   = nib_q;
		emit    = 1'b0;
		res.kind         = KIND_STATUS;
		res.payload_byte = '0;
		res.byte_index   = count_q;
		res.status       = ST_READ;
		res.ack          = ACK_NONE;

		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == CH_NUL) begin
					count_d        = '0;
					res.byte_index = '0;
					emit           = 1'b1;
				end else if (rx_byte == CH_START) begin
					phase_d = PH_DATA;
					sum_d   = '0;
					count_d = '0;
					colon_d = 1'b0;
					nib_d   = '0;
				end
			end
			PH_DATA: begin
				if (rx_byte == CH_NUL || rx_byte == CH_START) begin
					emit    = 1'b1;
					phase_d = PH_HUNT;
				end else if (rx_byte == CH_HASH) begin
					if (colon_q) begin
						emit       = 1'b1;
						res.status = ST_DEPRECATED;
						phase_d    = PH_HUNT;
					end else begin
						phase_d = PH_CK1;
					end
				end else if (count_inc >= {1'b0, limit}) begin
					// too long, drop the byte and end the packet
					emit    = 1'b1;
					phase_d = PH_HUNT;
				end else begin
					if (count_q == COLON_POS && rx_byte == CH_COLON)
						colon_d = 1'b1;
					emit             = 1'b1;
					res.kind         = KIND_BYTE;
					res.payload_byte = rx_byte;
					res.status       = ST_OK;
					count_d          = count_inc[INDEX_W-1:0];
					sum_d            = sum_q + rx_byte;
				end
			end
			PH_CK1: begin
				nib_d   = hex_value(rx_byte);
				phase_d = PH_CK2;
			end
			PH_CK2: begin
				emit    = 1'b1;
				phase_d = PH_HUNT;
				if (given == sum_q) begin
					res.status = ST_OK;
					res.ack    = ACK_PLUS;
				end else begin
					res.status = ST_CKSUM;
					res.ack    = ACK_MINUS;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// a passed payload byte always stays below the limit
	a_index_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && res.kind == KIND_BYTE |-> {1'b0, res.byte_index} + 12'd1 < {1'b0, limit})
		else $error("payload byte index reached limit");

	// checksum digits are only read after a '#' without the colon mark
	a_ck_after_hash: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_DATA && phase_d == PH_CK1 |-> rx_byte == CH_HASH && !colon_q)
		else $error("checksum phase entered without hash");

	// the count only grows by one within a packet
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_DATA && phase_d == PH_DATA |-> count_d == count_inc[INDEX_W-1:0])
		else $error("payload count skipped");

endmodule

`default_nettype wire

FILE: src/checksummed_packet_deframer.sv
`default_nettype none

// checksummed packet deframer for $payload#hh framed serial traffic
//
// s_axis: one received character per transfer in tdata[7:0]; zero means a
//   link read error. m_axis: one result per transfer, tuser tells a payload
//   byte (0) from an end of packet status (1); tdata carries the payload
//   byte, its index (or the payload length at the end), the status and the
//   acknowledge that the host should send back.
// cfg: one write channel for max_payload, always ready; write it only while
//   the block is idle. The effective limit is max_payload capped at
//   BUFFER_BYTES - 1.
// pipeline: a character accepted into the input register is parsed once the
//   output register can take its result; that result, if any, is offered there.
// throughput: one character per cycle while results are taken, limited by the
//   single pass through the parser state machine between the input and output
//   registers.
// reset: parser back to hunting for '$', sum and count cleared, limit set
//   to 2047, both registers empty.
// stall: while the output register holds a result that is not taken, the
//   input register holds its character and tready drops once it is full;
//   nothing is lost or repeated.
module checksummed_packet_deframer #(
	parameter int unsigned BUFFER_BYTES = cpd_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [7:0] payload_byte, [18:8] byte_index, [20:19] status, [22:21] ack,
	// [23] zero fill
	output logic [23:0]                      m_axis_tdata,
	output logic                             m_axis_tuser,  // [0] out_kind
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [cpd_pkg::INDEX_W-1:0] cfg_data       // max_payload
);
	import cpd_pkg::*;

	// largest usable limit, set by the receive buffer size
	localparam int unsigned CAP_INT = (BUFFER_BYTES - 1 > 2047) ? 2047 : BUFFER_BYTES - 1;
	localparam logic [INDEX_W-1:0] LIMIT_CAP = INDEX_W'(CAP_INT);

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                out_valid_q;
	res_t                res_q;
	logic [INDEX_W-1:0]  max_payload_q;
	logic [INDEX_W-1:0]  limit;
	logic                advance;
	logic                emit;
	res_t                res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_payload_q <= MAX_PAYLOAD_RST;
		else if (cfg_valid)
			max_payload_q <= cfg_data;
	end

	assign limit = (max_payload_q > LIMIT_CAP) ? LIMIT_CAP : max_payload_q;

	// parse the held character when the output register can take its result
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			byte_s1 <= s_axis_tdata;
	end

	cpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.limit   (limit),
		.emit    (emit),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= emit;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {1'b0, res_q.ack, res_q.status, res_q.byte_index,
		res_q.payload_byte};

	// payload results carry no status and no acknowledge
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_BYTE |-> res_q.status == ST_OK && res_q.ack == ACK_NONE)
		else $error("payload result with status or ack");

	// status results carry a zero payload byte
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_STATUS |-> res_q.payload_byte == '0)
		else $error("status result with payload byte");

	// a '+' goes with ok, a '-' with a checksum error, nothing otherwise
	a_ack_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == KIND_STATUS |->
		((res_q.status == ST_OK) == (res_q.ack == ACK_PLUS)) &&
		((res_q.status == ST_CKSUM) == (res_q.ack == ACK_MINUS)))
		else $error("ack does not match status");

	// backpressure only ever comes from a held character
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && out_valid_q && !m_axis_tready)
		else $error("input stalled without cause");

endmodule

`default_nettype wire
